// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the retirement queue back end (arpq_back).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define ARPQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("arpq: assertion violated");

// Condition must never be seen outside reset
`define ARPQ_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
	else $error("arpq: forbidden condition seen");

`else

`define ARPQ_ASSERT(lbl, clk, rstn, prop)
`define ARPQ_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== src/arpq_pkg.sv =====
// ----------------------------------------------------------------------------
// arpq_pkg
// Types and constants of the in-order retirement queue with cumulative ack.
// ----------------------------------------------------------------------------
package arpq_pkg;

	// Field widths
	localparam int SEQ_W       = 64;
	localparam int SIZE_W      = 32;
	localparam int HANDLE_W    = 32;
	localparam int KIND_W      = 2;
	localparam int DISP_W      = 3;
	localparam int COUNT_OUT_W = 6;
	localparam int BYTES_W     = 37;

	// Sizing
	localparam int DEF_QUEUE_DEPTH = 32;
	localparam int CMDQ_DEPTH      = 2;

	// Input item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_TRACK   = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_RELEASE = 2'd2,
		KIND_DRAIN   = 2'd3
	} kind_t;

	// Commands after classification by the front end
	typedef enum logic [2:0] {
		OP_TRACK   = 3'd0,
		OP_DROP    = 3'd1,
		OP_ACK     = 3'd2,
		OP_RELEASE = 3'd3,
		OP_DRAIN   = 3'd4
	} op_t;

	// Result dispositions
	typedef enum logic [DISP_W-1:0] {
		DISP_NONE    = 3'd0,
		DISP_ACK     = 3'd1,
		DISP_RELEASE = 3'd2,
		DISP_DRAIN   = 3'd3,
		DISP_DROP    = 3'd4
	} disp_t;

	// Back-end sequencer states
	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_SWEEP = 1'b1
	} state_t;

	typedef struct packed {
		op_t                      op;
		logic signed [SEQ_W-1:0]  seq;
		logic [SIZE_W-1:0]        size;
		logic [HANDLE_W-1:0]      handle;
	} cmd_t;

	typedef struct packed {
		logic signed [SEQ_W-1:0]  seq;
		logic [SIZE_W-1:0]        size;
		logic [HANDLE_W-1:0]      handle;
	} entry_t;

	typedef struct packed {
		logic signed [SEQ_W-1:0]  entry_seq;
		logic [SIZE_W-1:0]        entry_size;
		logic [HANDLE_W-1:0]      entry_handle;
		disp_t                    disposition;
		logic                     full_error;
		logic [COUNT_OUT_W-1:0]   live_count;
		logic [BYTES_W-1:0]       live_bytes;
		logic                     last;
	} result_t;

endpackage

// ===== src/arpq_if.sv =====
// ----------------------------------------------------------------------------
// arpq_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface arpq_item_if;
	logic                                  valid;
	logic                                  ready;
	logic [arpq_pkg::KIND_W-1:0]           kind;
	logic signed [arpq_pkg::SEQ_W-1:0]     seq;
	logic [arpq_pkg::SIZE_W-1:0]           payload_size;
	logic [arpq_pkg::HANDLE_W-1:0]         payload_handle;

	modport source (output valid, kind, seq, payload_size, payload_handle, input ready);
	modport sink (input valid, kind, seq, payload_size, payload_handle, output ready);
endinterface

interface arpq_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [arpq_pkg::SEQ_W-1:0]     entry_seq;
	logic [arpq_pkg::SIZE_W-1:0]           entry_size;
	logic [arpq_pkg::HANDLE_W-1:0]         entry_handle;
	logic [arpq_pkg::DISP_W-1:0]           disposition;
	logic                                  full_error;
	logic [arpq_pkg::COUNT_OUT_W-1:0]      live_count;
	logic [arpq_pkg::BYTES_W-1:0]          live_bytes;
	logic                                  last;

	modport source (output valid, entry_seq, entry_size, entry_handle, disposition,
		full_error, live_count, live_bytes, last, input ready);
	modport sink (input valid, entry_seq, entry_size, entry_handle, disposition,
		full_error, live_count, live_bytes, last, output ready);
endinterface

// ===== src/arpq_front.sv =====
// ----------------------------------------------------------------------------
// arpq_front
// Accepts input items and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module arpq_front (
	arpq_item_if.sink          item,
	output logic               push_valid,
	input  logic               push_ready,
	output arpq_pkg::cmd_t     push_cmd
);

	// Handshake passes straight into the command queue
	assign push_valid = item.valid;
	assign item.ready = push_ready;

	// Decode the kind; an empty track becomes a drop
	always_comb begin
		push_cmd.seq    = item.seq;
		push_cmd.size   = item.payload_size;
		push_cmd.handle = item.payload_handle;
		unique case (arpq_pkg::kind_t'(item.kind))
			arpq_pkg::KIND_TRACK: begin
				push_cmd.op = (item.payload_size == '0) ? arpq_pkg::OP_DROP
				                                        : arpq_pkg::OP_TRACK;
			end
			arpq_pkg::KIND_ACK:     push_cmd.op = arpq_pkg::OP_ACK;
			arpq_pkg::KIND_RELEASE: push_cmd.op = arpq_pkg::OP_RELEASE;
			arpq_pkg::KIND_DRAIN:   push_cmd.op = arpq_pkg::OP_DRAIN;
			default:                push_cmd.op = arpq_pkg::OP_TRACK;
		endcase
	end

endmodule

// ===== src/arpq_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// arpq_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module arpq_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  arpq_pkg::cmd_t     push_cmd,
	output logic               pop_valid,
	input  logic               pop_ready,
	output arpq_pkg::cmd_t     pop_cmd
);

	localparam int DEPTH = arpq_pkg::CMDQ_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	arpq_pkg::cmd_t  slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/arpq_back.sv =====
// ----------------------------------------------------------------------------
// arpq_back
// Executes commands on the payload store and sequences result transfers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arpq_back #(
	parameter int QUEUE_DEPTH = arpq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  arpq_pkg::cmd_t     cmd,
	arpq_result_if.source      result
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LCW   = arpq_pkg::COUNT_OUT_W;
	localparam int BW    = arpq_pkg::BYTES_W;

	// Payload store, read data registered
	arpq_pkg::entry_t      mem [QUEUE_DEPTH];
	arpq_pkg::entry_t      rdata_q;
	logic [PTR_W-1:0]      rd_addr;

	arpq_pkg::state_t      state_q, state_d;
	logic [PTR_W-1:0]      head_q, tail_q, head_nx, tail_nx;
	logic [CNT_W-1:0]      count_q;
	logic [BW-1:0]         bytes_q;

	arpq_pkg::cmd_t        cur_q;
	arpq_pkg::result_t     pend_q, out_q, out_d, pend_d;
	logic                  pend_v_q;
	logic                  ovalid_q;

	logic                  out_free, empty, full, is_sweep, below, qualify;
	logic                  take, sweep_pop, sweep_end;
	logic                  wr_en, pop_head, start, load_out, pend_load, pend_clear;
	logic                  clear_ptrs;

	logic [CNT_W-1:0]      cnt_inc, cnt_dec;
	logic [BW-1:0]         bytes_inc, bytes_dec;
	logic [PTR_W:0]        ptr_sum;
	logic [PTR_W-1:0]      exp_tail;

	// Status terms
	assign out_free  = !ovalid_q || result.ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_sweep  = (cmd.op inside {arpq_pkg::OP_ACK, arpq_pkg::OP_RELEASE,
	                                   arpq_pkg::OP_DRAIN});
	assign below     = ($signed(rdata_q.seq) < $signed(cur_q.seq));
	assign qualify   = !empty && ((cur_q.op != arpq_pkg::OP_ACK) || below);
	assign take      = (state_q == arpq_pkg::ST_IDLE) && cmd_valid && out_free;
	assign sweep_pop = (state_q == arpq_pkg::ST_SWEEP) && qualify && (!pend_v_q || out_free);
	assign sweep_end = (state_q == arpq_pkg::ST_SWEEP) && !qualify && out_free;

	assign head_nx   = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx   = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign cnt_inc   = count_q + 1'b1;
	assign cnt_dec   = count_q - 1'b1;
	assign bytes_inc = bytes_q + BW'(cmd.size);
	assign bytes_dec = bytes_q - BW'(rdata_q.size);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			arpq_pkg::ST_IDLE: begin
				if (take && is_sweep && !empty) begin
					state_d = arpq_pkg::ST_SWEEP;
				end
			end
			arpq_pkg::ST_SWEEP: begin
				if (sweep_end) begin
					state_d = arpq_pkg::ST_IDLE;
				end
			end
			default: state_d = arpq_pkg::ST_IDLE;
		endcase
	end

	// Control and result selection
	always_comb begin
		cmd_ready  = 1'b0;
		wr_en      = 1'b0;
		pop_head   = 1'b0;
		start      = 1'b0;
		load_out   = 1'b0;
		pend_load  = 1'b0;
		pend_clear = 1'b0;
		clear_ptrs = 1'b0;

		out_d              = '0;
		out_d.disposition  = arpq_pkg::DISP_NONE;
		out_d.live_count   = LCW'(count_q);
		out_d.live_bytes   = bytes_q;
		out_d.last         = 1'b1;

		pend_d              = '0;
		pend_d.entry_seq    = rdata_q.seq;
		pend_d.entry_size   = rdata_q.size;
		pend_d.entry_handle = rdata_q.handle;
		pend_d.disposition  = arpq_pkg::DISP_ACK;
		pend_d.live_count   = LCW'(cnt_dec);
		pend_d.live_bytes   = bytes_dec;
		case (cur_q.op)
			arpq_pkg::OP_RELEASE: pend_d.disposition = arpq_pkg::DISP_RELEASE;
			arpq_pkg::OP_DRAIN:   pend_d.disposition = arpq_pkg::DISP_DRAIN;
			default:              pend_d.disposition = arpq_pkg::DISP_ACK;
		endcase

		unique case (state_q)
			arpq_pkg::ST_IDLE: begin
				if (take) begin
					cmd_ready = 1'b1;
					unique case (cmd.op)
						arpq_pkg::OP_DROP: begin
							load_out           = 1'b1;
							out_d.entry_seq    = cmd.seq;
							out_d.entry_handle = cmd.handle;
							out_d.disposition  = arpq_pkg::DISP_DROP;
						end
						arpq_pkg::OP_TRACK: begin
							load_out = 1'b1;
							if (full) begin
								out_d.full_error = 1'b1;
							end else begin
								wr_en            = 1'b1;
								out_d.live_count = LCW'(cnt_inc);
								out_d.live_bytes = bytes_inc;
							end
						end
						arpq_pkg::OP_ACK, arpq_pkg::OP_RELEASE, arpq_pkg::OP_DRAIN: begin
							if (empty) begin
								// nothing held: single empty result
								load_out   = 1'b1;
								clear_ptrs = (cmd.op != arpq_pkg::OP_ACK);
							end else begin
								start = 1'b1;
							end
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			arpq_pkg::ST_SWEEP: begin
				if (sweep_pop) begin
					// retire head; previous entry is known not to be the last
					pop_head  = 1'b1;
					pend_load = 1'b1;
					if (pend_v_q) begin
						load_out   = 1'b1;
						out_d      = pend_q;
						out_d.last = 1'b0;
					end
				end else if (sweep_end) begin
					load_out   = 1'b1;
					pend_clear = 1'b1;
					clear_ptrs = (cur_q.op != arpq_pkg::OP_ACK);
					if (pend_v_q) begin
						out_d      = pend_q;
						out_d.last = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= arpq_pkg::ST_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			bytes_q  <= '0;
			pend_v_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				tail_q  <= tail_nx;
				count_q <= cnt_inc;
				bytes_q <= bytes_inc;
			end
			if (pop_head) begin
				head_q  <= head_nx;
				count_q <= cnt_dec;
				bytes_q <= bytes_dec;
			end
			if (clear_ptrs) begin
				head_q <= '0;
				tail_q <= '0;
			end
			if (pend_load) begin
				pend_v_q <= 1'b1;
			end else if (pend_clear) begin
				pend_v_q <= 1'b0;
			end
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= cmd;
		end
		if (pend_load) begin
			pend_q <= pend_d;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	// Store write at tail, registered read at head (next head while popping)
	assign rd_addr = pop_head ? head_nx : head_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= '{seq: cmd.seq, size: cmd.size, handle: cmd.handle};
		end
		rdata_q <= mem[rd_addr];
	end

	// Result channel
	assign result.valid        = ovalid_q;
	assign result.entry_seq    = out_q.entry_seq;
	assign result.entry_size   = out_q.entry_size;
	assign result.entry_handle = out_q.entry_handle;
	assign result.disposition  = out_q.disposition;
	assign result.full_error   = out_q.full_error;
	assign result.live_count   = out_q.live_count;
	assign result.live_bytes   = out_q.live_bytes;
	assign result.last         = out_q.last;

	// Expected tail from head and count, for checking
	assign ptr_sum  = {1'b0, head_q} + (PTR_W + 1)'(count_q);
	assign exp_tail = (ptr_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
	                  ? PTR_W'(ptr_sum - (PTR_W + 1)'(QUEUE_DEPTH)) : PTR_W'(ptr_sum);

	`ARPQ_ASSERT(a_tail_tracks_head, clk, arst_n, (tail_q == exp_tail))
	`ARPQ_ASSERT(a_sweep_starts_nonempty, clk, arst_n,
		((state_q == arpq_pkg::ST_SWEEP && !pend_v_q) |-> (count_q != '0)))
	`ARPQ_ASSERT(a_push_counts, clk, arst_n,
		(wr_en |=> (count_q == CNT_W'($past(count_q) + 1'b1))))
	`ARPQ_ASSERT_NEVER(a_bytes_without_entries, clk, arst_n,
		(count_q == '0 && bytes_q != '0))

endmodule

// ===== src/ack_retire_payload_queue.sv =====
// ----------------------------------------------------------------------------
// An item passes the command queue, then its result the output register; a sweep's
// first entry also passes the pending register. Throughput: while the result
// channel is not stalled, the back end takes one track or dropped payload per cycle,
// and an ack, release-all or drain retires one entry per cycle through the store's read port.
// Reset: pointers, counts and handshakes clear at once; store contents stay
// undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// ack_retire_payload_queue
// In-order payload retirement queue with cumulative ack, release and drain.
// ----------------------------------------------------------------------------
module ack_retire_payload_queue #(
	parameter int QUEUE_DEPTH = arpq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	arpq_item_if.sink      item,
	arpq_result_if.source  result
);

	logic            push_valid, push_ready;
	arpq_pkg::cmd_t  push_cmd;
	logic            cmd_valid, cmd_ready;
	arpq_pkg::cmd_t  cmd;

	// Front end: accept and classify
	arpq_front u_front (
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Command queue between the two halves
	arpq_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop_ready  (cmd_ready),
		.pop_cmd    (cmd)
	);

	// Back end: store, sweeps and result transfers
	arpq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.result     (result)
	);

endmodule

// ===== tb/sv/retire_order_checker.sv =====
// ----------------------------------------------------------------------------
// retire_order_checker
// Watches both channels of the retirement queue. Keeps its own copy of the
// queue, works out the results of every accepted item and compares each
// accepted result, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module retire_order_checker #(
	parameter int QUEUE_DEPTH = arpq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	arpq_item_if   item,
	arpq_result_if result,
	output int     mismatch_count,
	output int     pending_results
);
	import arpq_pkg::*;

	localparam int REPORT_LIMIT = 10;

	// Shadow copy of the queue
	entry_t             held [QUEUE_DEPTH];
	int                 head_idx;
	int                 tail_idx;
	int                 held_count;
	logic [BYTES_W-1:0] held_bytes;

	// Results still owed by the block, oldest first
	result_t            owed_results [$];
	int                 fail_tally = 0;

	// Report the front entry as retired and drop it from the shadow queue
	task automatic retire_front(input disp_t disp);
		result_t r;
		r = '0;
		r.entry_seq    = held[head_idx].seq;
		r.entry_size   = held[head_idx].size;
		r.entry_handle = held[head_idx].handle;
		r.disposition  = disp;
		head_idx       = (head_idx + 1) % QUEUE_DEPTH;
		held_count--;
		held_bytes     = held_bytes - BYTES_W'(held[head_idx == 0 ?
			QUEUE_DEPTH - 1 : head_idx - 1].size);
		r.live_count   = COUNT_OUT_W'(held_count);
		r.live_bytes   = held_bytes;
		owed_results   = {owed_results, r};
	endtask

	// Work out every result that one accepted item causes
	task automatic predict_item(input kind_t k, input logic signed [SEQ_W-1:0] s,
		input logic [SIZE_W-1:0] sz, input logic [HANDLE_W-1:0] h);
		result_t r;
		disp_t   disp;
		int      retired;
		r       = '0;
		r.last  = 1'b1;
		retired = 0;
		if (k == KIND_TRACK) begin
			if (sz == '0) begin
				// empty payload goes straight back, even when full
				r.entry_seq    = s;
				r.entry_handle = h;
				r.disposition  = DISP_DROP;
			end else if (held_count >= QUEUE_DEPTH) begin
				r.full_error = 1'b1;
			end else begin
				held[tail_idx].seq    = s;
				held[tail_idx].size   = sz;
				held[tail_idx].handle = h;
				tail_idx   = (tail_idx + 1) % QUEUE_DEPTH;
				held_count++;
				held_bytes = held_bytes + BYTES_W'(sz);
			end
			r.live_count = COUNT_OUT_W'(held_count);
			r.live_bytes = held_bytes;
			owed_results = {owed_results, r};
		end else begin
			disp = (k == KIND_ACK) ? DISP_ACK : (k == KIND_RELEASE) ? DISP_RELEASE : DISP_DRAIN;
			// cumulative ack stops at the first entry not below the bound
			while (held_count > 0 && (k != KIND_ACK ||
					$signed(held[head_idx].seq) < $signed(s))) begin
				retire_front(disp);
				retired++;
			end
			if (k != KIND_ACK) begin
				head_idx = 0;
				tail_idx = 0;
			end
			if (retired == 0) begin
				r.live_count = COUNT_OUT_W'(held_count);
				r.live_bytes = held_bytes;
				owed_results = {owed_results, r};
			end else begin
				owed_results[$].last = 1'b1;
			end
		end
	endtask

	// Compare one accepted result with the oldest owed one
	task automatic check_result();
		result_t seen;
		result_t want;
		seen.entry_seq    = result.entry_seq;
		seen.entry_size   = result.entry_size;
		seen.entry_handle = result.entry_handle;
		seen.disposition  = disp_t'(result.disposition);
		seen.full_error   = result.full_error;
		seen.live_count   = result.live_count;
		seen.live_bytes   = result.live_bytes;
		seen.last         = result.last;
		if (owed_results.size() == 0) begin
			fail_tally++;
			if (fail_tally <= REPORT_LIMIT)
				$display("retire check: unexpected result seq %0d disposition %0d last %b",
					seen.entry_seq, seen.disposition, seen.last);
		end else begin
			want = owed_results[0];
			owed_results.delete(0);
			if (seen !== want) begin
				fail_tally++;
				if (fail_tally <= REPORT_LIMIT) begin
					$display("retire check: seq exp %0d got %0d, size exp %0d got %0d",
						want.entry_seq, seen.entry_seq, want.entry_size, seen.entry_size);
					$display("  handle exp %h got %h, disposition exp %0d got %0d",
						want.entry_handle, seen.entry_handle,
						want.disposition, seen.disposition);
					$display("  full_error exp %b got %b, live_count exp %0d got %0d",
						want.full_error, seen.full_error, want.live_count, seen.live_count);
					$display("  live_bytes exp %0d got %0d, last exp %b got %b",
						want.live_bytes, seen.live_bytes, want.last, seen.last);
				end
			end
		end
	endtask

	// Items first: no result can come out at the edge its item goes in
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_idx   = 0;
			tail_idx   = 0;
			held_count = 0;
			held_bytes = '0;
			owed_results.delete();
			pending_results <= 0;
		end else begin
			if (item.valid && item.ready)
				predict_item(kind_t'(item.kind), item.seq, item.payload_size,
					item.payload_handle);
			if (result.valid && result.ready)
				check_result();
			pending_results <= owed_results.size();
			mismatch_count  <= fail_tally;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives tracks, cumulative acks, release-all and drain into the retirement
// queue: a directed opening, a fill against a held-off receiver, then random
// traffic in phases of sender and receiver idling. Checking is done by the
// retire_order_checker beside the block; this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import arpq_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int RANDOM_ITEMS   = 320;
	localparam int HOLD_CYCLES    = 300;
	// Longest quiet stretch of a correct run is the receiver hold-off
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 40;

	localparam logic signed [SEQ_W-1:0] SEQ_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [SEQ_W-1:0] SEQ_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	logic clk;
	logic arst_n;

	arpq_item_if   item_ch ();
	arpq_result_if result_ch ();

	int mismatch_count;
	int pending_results;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_token;
	int items_sent;
	logic signed [SEQ_W-1:0] seq_cursor;

	ack_retire_payload_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	retire_order_checker queue_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item_ch),
		.result          (result_ch),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Offer one item, with random idle cycles first, and wait for its transfer
	task automatic offer(input kind_t k, input logic signed [SEQ_W-1:0] s,
		input logic [SIZE_W-1:0] sz, input logic [HANDLE_W-1:0] h);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.kind           <= k;
		item_ch.seq            <= s;
		item_ch.payload_size   <= sz;
		item_ch.payload_handle <= h;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	// Stop offering until every owed result has come back
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	// Mostly small sizes, some over the whole range, a few empty payloads
	function automatic logic [SIZE_W-1:0] pick_size(input bit allow_empty);
		int roll;
		roll = $urandom_range(99);
		if (allow_empty && roll < 5)
			return '0;
		if (roll < 15)
			return ($urandom == 0) ? 32'd1 : $urandom;
		return $urandom_range(1, 4096);
	endfunction

	// Tracks with rising sequence numbers
	task automatic track_run(input int count, input bit allow_empty);
		for (int i = 0; i < count; i++) begin
			seq_cursor = seq_cursor + $urandom_range(1, 8);
			offer(KIND_TRACK, seq_cursor, pick_size(allow_empty), $urandom);
		end
	endtask

	// One random sequence: track runs, acks behind the cursor, sweeps, noise
	task automatic random_step();
		int pick;
		pick = $urandom_range(99);
		if (pick < 46)
			track_run($urandom_range(1, 6), 1'b1);
		else if (pick < 76)
			offer(KIND_ACK, seq_cursor - $urandom_range(0, 48), $urandom, $urandom);
		else if (pick < 83)
			offer(KIND_RELEASE, {$urandom, $urandom}, $urandom, $urandom);
		else if (pick < 90)
			offer(KIND_DRAIN, {$urandom, $urandom}, $urandom, $urandom);
		else if (pick < 92)
			track_run(34, 1'b0);
		else
			offer(kind_t'($urandom_range(3)), {$urandom, $urandom}, pick_size(1'b1),
				$urandom);
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin : receiver
		int hold_left;
		int hold_served;
		hold_left   = 0;
		hold_served = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_served != hold_token) begin
				hold_served = hold_token;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int random_base;
		arst_n                 <= 1'b0;
		item_ch.valid          <= 1'b0;
		item_ch.kind           <= KIND_TRACK;
		item_ch.seq            <= '0;
		item_ch.payload_size   <= '0;
		item_ch.payload_handle <= '0;
		send_idle_pct  = 0;
		recv_stall_pct <= 0;
		hold_token     <= 0;
		items_sent     = 0;
		seq_cursor     = -64'sd1500;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sweeps on an empty queue
		offer(KIND_DRAIN, '0, '0, '0);
		offer(KIND_RELEASE, SEQ_MAX, '1, '1);
		offer(KIND_ACK, '0, '0, '0);
		// Empty payload, then field extremes
		offer(KIND_TRACK, SEQ_MIN, '0, 32'hFFFF_FFFF);
		offer(KIND_TRACK, SEQ_MIN, 32'hFFFF_FFFF, '0);
		offer(KIND_TRACK, SEQ_MAX, 32'd1, 32'hFFFF_FFFF);
		offer(KIND_TRACK, -64'sd1, 32'h8000_0000, 32'h5A5A_A5A5);
		// Stale ack, partial ack across the sign, repeated ack
		offer(KIND_ACK, SEQ_MIN, '0, '0);
		offer(KIND_ACK, SEQ_MAX, '0, '0);
		offer(KIND_ACK, SEQ_MAX, '0, '0);
		// Empty payload with entries held, then drain what is left
		offer(KIND_TRACK, '0, '0, '0);
		offer(KIND_DRAIN, '0, '0, '0);
		offer(KIND_TRACK, 64'sd5, 32'd7, 32'd1);
		offer(KIND_TRACK, 64'sd6, 32'd9, 32'd2);
		offer(KIND_ACK, 64'sd7, '0, '0);
		offer(KIND_TRACK, 64'sd10, 32'd3, 32'd3);
		offer(KIND_RELEASE, '0, '0, '0);
		offer(KIND_ACK, SEQ_MAX, '0, '0);
		settle();

		// Fill past full while the receiver holds off, so the input backs up
		hold_token <= hold_token + 1;
		track_run(36, 1'b0);
		offer(KIND_TRACK, seq_cursor, '0, $urandom);
		offer(KIND_ACK, seq_cursor - 40, '0, '0);
		offer(KIND_DRAIN, '0, '0, '0);
		settle();

		// Random traffic in idling phases
		random_base = items_sent;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct <= 0;
			end
			1: begin
				send_idle_pct  = 58;
				recv_stall_pct <= 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct <= 58;
			end
			default: begin
				send_idle_pct  = 7;
				recv_stall_pct <= 7;
			end
			endcase
			while (items_sent - random_base < (phase + 1) * RANDOM_ITEMS / 4)
				random_step();
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
